### hdl/svpwm_pkg.sv
// Shared types, widths, codes and sector tables for the space-vector PWM timing core.
package svpwm_pkg;

	localparam int IN_W     = 17;
	localparam int VEC_W    = 19;
	localparam int TIME_W   = 19;
	localparam int REST_W   = 21;
	localparam int PERIOD_W = 16;
	localparam int SECTOR_W = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam int HALF_SQRT3_Q15 = 28378;

	localparam logic signed [TIME_W-1:0] TIME_FULL     = 19'sd32767;
	localparam logic [PERIOD_W-1:0]      PERIOD_RESET  = 16'd32767;

	localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_MODE = 2'd1;

	localparam logic MODE_SEVEN = 1'b0;
	localparam logic MODE_FIVE  = 1'b1;

	localparam logic [SECTOR_W-1:0] SECTOR_ZERO   = 3'd0;
	localparam logic [SECTOR_W-1:0] SECTOR_UNUSED = 3'd7;

	localparam logic [1:0] PH_A = 2'd0;
	localparam logic [1:0] PH_B = 2'd1;
	localparam logic [1:0] PH_C = 2'd2;

	// Phase that switches first, second and third in each sector.
	localparam logic [1:0] FIRST_PH [8] = '{PH_A, PH_B, PH_A, PH_A, PH_C, PH_B, PH_C, PH_A};
	localparam logic [1:0] SECOND_PH [8] = '{PH_A, PH_A, PH_C, PH_B, PH_B, PH_C, PH_A, PH_A};
	localparam logic [1:0] THIRD_PH [8] = '{PH_A, PH_C, PH_B, PH_C, PH_A, PH_A, PH_B, PH_A};

	typedef struct packed {
		logic [SECTOR_W-1:0]    sector;
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [VEC_W-1:0] z;
	} svpwm_vec_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] pwm_period;
		logic                segment_mode;
	} svpwm_cfg_t;

endpackage

### hdl/svpwm_if.sv
// Channel interfaces for the space-vector PWM timing core.
interface svpwm_in_if;
	logic valid;
	logic ready;
	logic signed [svpwm_pkg::IN_W-1:0] u_alpha;
	logic signed [svpwm_pkg::IN_W-1:0] u_beta;
	modport source (output valid, output u_alpha, output u_beta, input ready);
	modport sink (input valid, input u_alpha, input u_beta, output ready);
endinterface

interface svpwm_out_if;
	logic valid;
	logic ready;
	logic signed [svpwm_pkg::TIME_W-1:0] time_a;
	logic signed [svpwm_pkg::TIME_W-1:0] time_b;
	logic signed [svpwm_pkg::TIME_W-1:0] time_c;
	logic [svpwm_pkg::SECTOR_W-1:0]      sector;
	logic [svpwm_pkg::PERIOD_W-1:0]      first_on_time;
	modport source (output valid, output time_a, output time_b, output time_c,
		output sector, output first_on_time, input ready);
	modport sink (input valid, input time_a, input time_b, input time_c,
		input sector, input first_on_time, output ready);
endinterface

interface svpwm_cfg_if;
	logic valid;
	logic ready;
	logic [svpwm_pkg::CFG_IDX_W-1:0]  index;
	logic [svpwm_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/svpwm_xform.sv
// Input register, inverse Clarke transform, sector detection and X/Y/Z vector register.
module svpwm_xform (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [svpwm_pkg::IN_W-1:0] u_alpha,
	input  logic signed [svpwm_pkg::IN_W-1:0] u_beta,
	output logic                             vec_valid,
	input  logic                             vec_ready,
	output svpwm_pkg::svpwm_vec_t            vec
);

	logic                              valid_s1;
	logic signed [svpwm_pkg::IN_W-1:0] alpha_s1;
	logic signed [svpwm_pkg::IN_W-1:0] beta_s1;
	logic                              valid_s2;
	svpwm_pkg::svpwm_vec_t             vec_s2;

	logic                               adv_s1;
	logic                               adv_s2;
	logic signed [31:0]                 prod;
	logic signed [31:0]                 prod_adj;
	logic signed [17:0]                 beta_adj;
	logic signed [svpwm_pkg::VEC_W-1:0] k;
	logic signed [svpwm_pkg::VEC_W-1:0] h;
	logic signed [svpwm_pkg::VEC_W-1:0] beta_x;
	svpwm_pkg::svpwm_vec_t              vec_d;

	assign adv_s2   = !valid_s2 || vec_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_comb begin
		// Both quotients truncate toward zero, so negative values are biased first.
		prod     = 32'(alpha_s1) * svpwm_pkg::HALF_SQRT3_Q15;
		prod_adj = prod + $signed({17'b0, {15{prod[31]}}});
		k        = svpwm_pkg::VEC_W'($signed(prod_adj[31:15]));
		beta_adj = 18'(beta_s1) + $signed({17'b0, beta_s1[svpwm_pkg::IN_W-1]});
		h        = svpwm_pkg::VEC_W'($signed(beta_adj[17:1]));
		beta_x   = svpwm_pkg::VEC_W'(beta_s1);
		vec_d.x  = beta_x;
		vec_d.y  = h + k;
		vec_d.z  = h - k;
		vec_d.sector = {(h + k) < 0, k > h, beta_x > 0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			alpha_s1 <= u_alpha;
			beta_s1  <= u_beta;
		end
		if (adv_s2 && valid_s1) begin
			vec_s2 <= vec_d;
		end
	end

	assign vec_valid = valid_s2;
	assign vec       = vec_s2;

	// All three phase voltages can never be positive at once.
	a_no_sector_seven: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> vec_s2.sector != svpwm_pkg::SECTOR_UNUSED)
		else $error("sector seven reached the vector register");

	// A word stalled in the vector register keeps its contents.
	a_vec_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !vec_ready |=> valid_s2 && $stable(vec_s2))
		else $error("stalled vector word changed");

	// The sector flags follow the signs of X and Y.
	a_sector_signs: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (vec_s2.sector[0] == (vec_s2.x > 0)) &&
			(vec_s2.sector[2] == (vec_s2.y < 0)))
		else $error("sector flags disagree with vector signs");

endmodule

### hdl/svpwm_timing.sv
// Vector times, phase ordering and the result register with the held first on-time.
module svpwm_timing (
	input  logic                  clk,
	input  logic                  arst_n,
	input  svpwm_pkg::svpwm_cfg_t cfg,
	input  logic                  vec_valid,
	output logic                  vec_ready,
	input  svpwm_pkg::svpwm_vec_t vec,
	svpwm_out_if.source           result
);

	logic                                 valid_s3;
	logic signed [svpwm_pkg::TIME_W-1:0]  time_a_s3;
	logic signed [svpwm_pkg::TIME_W-1:0]  time_b_s3;
	logic signed [svpwm_pkg::TIME_W-1:0]  time_c_s3;
	logic [svpwm_pkg::SECTOR_W-1:0]       sector_s3;
	logic [svpwm_pkg::PERIOD_W-1:0]       first_on_s3;
	logic [svpwm_pkg::PERIOD_W-1:0]       held_q;

	logic                                 adv_s3;
	logic                                 active;
	logic signed [svpwm_pkg::VEC_W-1:0]   t1;
	logic signed [svpwm_pkg::VEC_W-1:0]   t2;
	logic signed [svpwm_pkg::REST_W-1:0]  period_x;
	logic signed [svpwm_pkg::REST_W-1:0]  rest;
	logic signed [svpwm_pkg::REST_W-1:0]  first;
	logic signed [svpwm_pkg::REST_W-1:0]  second;
	logic signed [svpwm_pkg::REST_W-1:0]  third;
	logic signed [svpwm_pkg::TIME_W-1:0]  t [3];
	logic [1:0]                           fi;
	logic [1:0]                           se;
	logic [svpwm_pkg::PERIOD_W-1:0]       first_on_d;

	assign adv_s3    = !valid_s3 || result.ready;
	assign vec_ready = adv_s3;

	always_comb begin
		t1 = '0;
		t2 = '0;
		case (vec.sector)
			3'd1: begin
				t1 = vec.z;
				t2 = vec.y;
			end
			3'd2: begin
				t1 = vec.y;
				t2 = -vec.x;
			end
			3'd3: begin
				t1 = -vec.z;
				t2 = vec.x;
			end
			3'd4: begin
				t1 = -vec.x;
				t2 = vec.z;
			end
			3'd5: begin
				t1 = vec.x;
				t2 = -vec.y;
			end
			3'd6: begin
				t1 = -vec.y;
				t2 = -vec.z;
			end
			default: begin
				t1 = '0;
				t2 = '0;
			end
		endcase

		active   = (vec.sector != svpwm_pkg::SECTOR_ZERO) &&
			(vec.sector != svpwm_pkg::SECTOR_UNUSED);
		period_x = $signed({5'b0, cfg.pwm_period});
		rest     = period_x - svpwm_pkg::REST_W'(t1) - svpwm_pkg::REST_W'(t2);
		if (rest <= 0) begin
			first = '0;
		end else if (cfg.segment_mode == svpwm_pkg::MODE_FIVE) begin
			first = rest;
		end else begin
			first = rest >>> 1;
		end
		second = first + svpwm_pkg::REST_W'(t1);
		if (cfg.segment_mode == svpwm_pkg::MODE_FIVE) begin
			third = svpwm_pkg::REST_W'(svpwm_pkg::TIME_FULL);
		end else begin
			third = second + svpwm_pkg::REST_W'(t2);
		end

		fi = svpwm_pkg::FIRST_PH[vec.sector];
		se = svpwm_pkg::SECOND_PH[vec.sector];
		for (int p = 0; p < 3; p++) begin
			if (!active) begin
				t[p] = svpwm_pkg::TIME_FULL;
			end else if (2'(p) == fi) begin
				t[p] = $signed(first[svpwm_pkg::TIME_W-1:0]);
			end else if (2'(p) == se) begin
				t[p] = $signed(second[svpwm_pkg::TIME_W-1:0]);
			end else begin
				t[p] = $signed(third[svpwm_pkg::TIME_W-1:0]);
			end
		end

		first_on_d = active ? first[svpwm_pkg::PERIOD_W-1:0] : held_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			held_q   <= '0;
		end else begin
			if (adv_s3) begin
				valid_s3 <= vec_valid;
			end
			if (adv_s3 && vec_valid && active) begin
				held_q <= first[svpwm_pkg::PERIOD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && vec_valid) begin
			time_a_s3   <= t[0];
			time_b_s3   <= t[1];
			time_c_s3   <= t[2];
			sector_s3   <= vec.sector;
			first_on_s3 <= first_on_d;
		end
	end

	assign result.valid         = valid_s3;
	assign result.time_a        = time_a_s3;
	assign result.time_b        = time_b_s3;
	assign result.time_c        = time_c_s3;
	assign result.sector        = sector_s3;
	assign result.first_on_time = first_on_s3;

	// The zero vector drives every phase to the full count.
	a_zero_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && sector_s3 == svpwm_pkg::SECTOR_ZERO |->
			time_a_s3 == svpwm_pkg::TIME_FULL && time_b_s3 == svpwm_pkg::TIME_FULL &&
			time_c_s3 == svpwm_pkg::TIME_FULL)
		else $error("zero vector without full compare times");

	// The presented first on-time always matches the held value.
	a_held_match: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> first_on_s3 == held_q)
		else $error("first on-time differs from held value");

	// In five-segment mode one phase of an active sector stays at the full count.
	a_five_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && cfg.segment_mode == svpwm_pkg::MODE_FIVE &&
		sector_s3 != svpwm_pkg::SECTOR_ZERO |->
			time_a_s3 == svpwm_pkg::TIME_FULL || time_b_s3 == svpwm_pkg::TIME_FULL ||
			time_c_s3 == svpwm_pkg::TIME_FULL)
		else $error("five-segment word without a clamped phase");

endmodule

### hdl/space_vector_pwm_timing_core.sv
// Top level of the space-vector PWM timing core: configuration registers and datapath.
//
// One alpha/beta voltage word enters on the sample channel per PWM period; the
// result channel returns the three phase compare times, the sector code and the
// earliest phase on-time for that word. Words are accepted when sample.valid and
// sample.ready are both high, and results leave when result.valid and result.ready
// are both high. The datapath has three registers: the input register, the X/Y/Z
// vector register after the single constant multiply, and the result register.
// Each word passes through them in order, and while result.ready stays high one word
// per cycle is sustained. When the receiver stalls, each stage holds its word and
// sample.ready falls only once all three stages are full. The cfg channel writes
// pwm_period (index 0) and segment_mode (index 1) at any time it is valid; it is
// always ready and should be used only while no word is in flight. Reset empties
// the pipeline, sets pwm_period to 32767, selects seven-segment modulation and
// clears the held first on-time.
module space_vector_pwm_timing_core (
	input  logic        clk,
	input  logic        arst_n,
	svpwm_in_if.sink    sample,
	svpwm_out_if.source result,
	svpwm_cfg_if.sink   cfg
);

	svpwm_pkg::svpwm_cfg_t cfg_q;
	svpwm_pkg::svpwm_vec_t vec;
	logic                  vec_valid;
	logic                  vec_ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pwm_period   <= svpwm_pkg::PERIOD_RESET;
			cfg_q.segment_mode <= svpwm_pkg::MODE_SEVEN;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				svpwm_pkg::REG_PWM_PERIOD: begin
					cfg_q.pwm_period <= cfg.data;
				end
				svpwm_pkg::REG_SEGMENT_MODE: begin
					cfg_q.segment_mode <= cfg.data[0];
				end
				default: begin
				end
			endcase
		end
	end

	svpwm_xform u_xform (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.u_alpha   (sample.u_alpha),
		.u_beta    (sample.u_beta),
		.vec_valid (vec_valid),
		.vec_ready (vec_ready),
		.vec       (vec)
	);

	svpwm_timing u_timing (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.vec_valid (vec_valid),
		.vec_ready (vec_ready),
		.vec       (vec),
		.result    (result)
	);

endmodule

### bench/tb_top.sv
// Testbench for the space-vector PWM timing core: directed and random words checked against a predictor.
module tb_top;

	localparam int LONG_HOLD_CYCLES = 64;
	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int MAX_REPORTS = 10;
	localparam int RESET_CYCLES = 12;
	localparam longint Q15_ONE = 32768;
	localparam logic [svpwm_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd2;

	typedef struct packed {
		logic signed [svpwm_pkg::TIME_W-1:0] time_a;
		logic signed [svpwm_pkg::TIME_W-1:0] time_b;
		logic signed [svpwm_pkg::TIME_W-1:0] time_c;
		logic [svpwm_pkg::SECTOR_W-1:0]      sector;
		logic [svpwm_pkg::PERIOD_W-1:0]      first_on_time;
	} timing_t;

	typedef struct packed {
		logic signed [svpwm_pkg::IN_W-1:0] alpha;
		logic signed [svpwm_pkg::IN_W-1:0] beta;
		logic                              fixed;
		timing_t                           timing;
	} vector_row_t;

	typedef struct packed {
		logic [svpwm_pkg::PERIOD_W-1:0] period;
		logic                           mode;
		logic                           drawn;
		logic                           no_gaps;
		logic                           hold_off;
		logic                           pause;
		logic [15:0]                    words;
	} phase_t;

	// Only the first word after reset has its result typed in; the rest go through the predictor.
	localparam vector_row_t VECTORS [25] = '{
		'{0, 0, 1'b1, '{svpwm_pkg::TIME_FULL, svpwm_pkg::TIME_FULL, svpwm_pkg::TIME_FULL,
			svpwm_pkg::SECTOR_ZERO, 16'd0}},
		'{65535, 0, 1'b0, '0},
		'{-65536, 0, 1'b0, '0},
		'{0, 65535, 1'b0, '0},
		'{0, -65536, 1'b0, '0},
		'{65535, 65535, 1'b0, '0},
		'{-65536, -65536, 1'b0, '0},
		'{65535, -65536, 1'b0, '0},
		'{-65536, 65535, 1'b0, '0},
		'{0, 0, 1'b0, '0},
		'{1, 1, 1'b0, '0},
		'{-1, -1, 1'b0, '0},
		'{1, -1, 1'b0, '0},
		'{-2, 1, 1'b0, '0},
		'{2, 0, 1'b0, '0},
		'{-2, 0, 1'b0, '0},
		'{0, 2, 1'b0, '0},
		'{0, -2, 1'b0, '0},
		'{28378, 16384, 1'b0, '0},
		'{0, 32767, 1'b0, '0},
		'{-28378, 16384, 1'b0, '0},
		'{-28378, -16384, 1'b0, '0},
		'{0, -32767, 1'b0, '0},
		'{28378, -16384, 1'b0, '0},
		'{-1, 0, 1'b0, '0}
	};

	localparam phase_t PHASES [10] = '{
		'{16'd65535, svpwm_pkg::MODE_SEVEN, 1'b0, 1'b0, 1'b0, 1'b1, 16'd180},
		'{16'd1, svpwm_pkg::MODE_FIVE, 1'b0, 1'b1, 1'b1, 1'b0, 16'd180},
		'{16'd0, svpwm_pkg::MODE_SEVEN, 1'b0, 1'b0, 1'b0, 1'b0, 16'd180},
		'{16'd65535, svpwm_pkg::MODE_FIVE, 1'b0, 1'b0, 1'b0, 1'b0, 16'd180},
		'{16'd0, svpwm_pkg::MODE_FIVE, 1'b0, 1'b1, 1'b0, 1'b0, 16'd180},
		'{16'd1, svpwm_pkg::MODE_SEVEN, 1'b0, 1'b0, 1'b1, 1'b0, 16'd180},
		'{16'd0, svpwm_pkg::MODE_SEVEN, 1'b1, 1'b0, 1'b0, 1'b0, 16'd190},
		'{16'd0, svpwm_pkg::MODE_SEVEN, 1'b1, 1'b1, 1'b0, 1'b0, 16'd190},
		'{16'd0, svpwm_pkg::MODE_SEVEN, 1'b1, 1'b0, 1'b0, 1'b1, 16'd190},
		'{16'd0, svpwm_pkg::MODE_SEVEN, 1'b1, 1'b0, 1'b0, 1'b0, 16'd190}
	};

	logic clk;
	logic arst_n;

	svpwm_in_if  sample_ch();
	svpwm_out_if result_ch();
	svpwm_cfg_if cfg_ch();

	space_vector_pwm_timing_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	logic [svpwm_pkg::PERIOD_W-1:0] period_setting;
	logic                           mode_setting;
	logic [svpwm_pkg::PERIOD_W-1:0] held_on_time;
	timing_t                        pending_timings [$];
	int                             mismatches = 0;
	int                             idle_cycles = 0;
	bit                             no_gaps = 1'b0;
	bit                             hold_off_req = 1'b0;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic timing_t predict_timing(
			input logic signed [svpwm_pkg::IN_W-1:0] alpha,
			input logic signed [svpwm_pkg::IN_W-1:0] beta);
		longint a, b, k, h, x, y, z, t1, t2, rest, first;
		longint ph_time [3];
		int first_ph, second_ph, third_ph;
		logic [svpwm_pkg::SECTOR_W-1:0] sec;
		timing_t res;
		a = longint'(alpha);
		b = longint'(beta);
		k = (a * svpwm_pkg::HALF_SQRT3_Q15) / Q15_ONE;
		h = b / 2;
		x = b;
		y = h + k;
		z = h - k;
		sec = {(-h - k) > 0, (k - h) > 0, b > 0};
		t1 = 0;
		t2 = 0;
		first_ph = 0;
		second_ph = 0;
		third_ph = 0;
		case (sec)
		3'd1: begin
			t1 = z; t2 = y; first_ph = 1; second_ph = 0; third_ph = 2;
		end
		3'd2: begin
			t1 = y; t2 = -x; first_ph = 0; second_ph = 2; third_ph = 1;
		end
		3'd3: begin
			t1 = -z; t2 = x; first_ph = 0; second_ph = 1; third_ph = 2;
		end
		3'd4: begin
			t1 = -x; t2 = z; first_ph = 2; second_ph = 1; third_ph = 0;
		end
		3'd5: begin
			t1 = x; t2 = -y; first_ph = 1; second_ph = 2; third_ph = 0;
		end
		3'd6: begin
			t1 = -y; t2 = -z; first_ph = 2; second_ph = 0; third_ph = 1;
		end
		default: ;
		endcase
		ph_time[0] = longint'(svpwm_pkg::TIME_FULL);
		ph_time[1] = longint'(svpwm_pkg::TIME_FULL);
		ph_time[2] = longint'(svpwm_pkg::TIME_FULL);
		if (sec != svpwm_pkg::SECTOR_ZERO && sec != svpwm_pkg::SECTOR_UNUSED) begin
			rest = longint'(period_setting) - t1 - t2;
			if (mode_setting == svpwm_pkg::MODE_FIVE)
				first = (rest > 0) ? rest : 0;
			else
				first = (rest > 0) ? rest / 2 : 0;
			ph_time[first_ph] = first;
			ph_time[second_ph] = first + t1;
			if (mode_setting == svpwm_pkg::MODE_SEVEN)
				ph_time[third_ph] = first + t1 + t2;
			held_on_time = first[svpwm_pkg::PERIOD_W-1:0];
		end
		res.time_a = ph_time[0][svpwm_pkg::TIME_W-1:0];
		res.time_b = ph_time[1][svpwm_pkg::TIME_W-1:0];
		res.time_c = ph_time[2][svpwm_pkg::TIME_W-1:0];
		res.sector = sec;
		res.first_on_time = held_on_time;
		return res;
	endfunction

	function automatic logic signed [svpwm_pkg::IN_W-1:0] draw_component();
		case ($urandom_range(0, 9))
		0: return svpwm_pkg::IN_W'(int'($urandom_range(0, 8)) - 4);
		1: return ($urandom_range(0, 1) == 0) ? svpwm_pkg::IN_W'(-65536) :
			svpwm_pkg::IN_W'(65535);
		default: return svpwm_pkg::IN_W'($urandom());
		endcase
	endfunction

	task automatic flag_mismatch(input string what, input timing_t want, input timing_t got);
		if (mismatches < MAX_REPORTS)
			$display("%s: expected a=%0d b=%0d c=%0d sector=%0d first=%0d, ", what,
				want.time_a, want.time_b, want.time_c, want.sector, want.first_on_time,
				"got a=%0d b=%0d c=%0d sector=%0d first=%0d",
				got.time_a, got.time_b, got.time_c, got.sector, got.first_on_time);
		mismatches++;
	endtask

	task automatic send_word(input logic signed [svpwm_pkg::IN_W-1:0] alpha,
			input logic signed [svpwm_pkg::IN_W-1:0] beta, input logic fixed,
			input timing_t fixed_timing);
		int gap;
		timing_t predicted;
		gap = no_gaps ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.u_alpha <= alpha;
		sample_ch.u_beta <= beta;
		do @(posedge clk); while (!sample_ch.ready);
		predicted = predict_timing(alpha, beta);
		pending_timings.push_back(fixed ? fixed_timing : predicted);
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		sample_ch.valid <= 1'b0;
		do @(negedge clk); while (pending_timings.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [svpwm_pkg::CFG_IDX_W-1:0] index,
			input logic [svpwm_pkg::CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		if (index == svpwm_pkg::REG_PWM_PERIOD)
			period_setting = data;
		else if (index == svpwm_pkg::REG_SEGMENT_MODE)
			mode_setting = data[0];
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int gap;
		timing_t got;
		timing_t want;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
			end
			gap = no_gaps ? 0 : $urandom_range(0, 9);
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			got.time_a = result_ch.time_a;
			got.time_b = result_ch.time_b;
			got.time_c = result_ch.time_c;
			got.sector = result_ch.sector;
			got.first_on_time = result_ch.first_on_time;
			if (pending_timings.size() == 0) begin
				flag_mismatch("Unexpected result word", '0, got);
			end else begin
				want = pending_timings.pop_front();
				if (got.time_a !== want.time_a || got.time_b !== want.time_b ||
						got.time_c !== want.time_c || got.sector !== want.sector ||
						got.first_on_time !== want.first_on_time)
					flag_mismatch("Wrong result word", want, got);
			end
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [svpwm_pkg::PERIOD_W-1:0] period_word;
		logic [svpwm_pkg::CFG_DATA_W-1:0] mode_word;
		sample_ch.valid = 1'b0;
		sample_ch.u_alpha = '0;
		sample_ch.u_beta = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = svpwm_pkg::REG_PWM_PERIOD;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		period_setting = svpwm_pkg::PERIOD_RESET;
		mode_setting = svpwm_pkg::MODE_SEVEN;
		held_on_time = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (VECTORS[i])
			send_word(VECTORS[i].alpha, VECTORS[i].beta, VECTORS[i].fixed, VECTORS[i].timing);
		foreach (PHASES[p]) begin
			wait_for_results();
			period_word = PHASES[p].drawn ?
				svpwm_pkg::PERIOD_W'($urandom_range(0, 65535)) : PHASES[p].period;
			mode_word = svpwm_pkg::CFG_DATA_W'($urandom());
			mode_word[0] = PHASES[p].drawn ? 1'($urandom_range(0, 1)) : PHASES[p].mode;
			write_reg(svpwm_pkg::REG_PWM_PERIOD, period_word);
			write_reg(svpwm_pkg::REG_SEGMENT_MODE, mode_word);
			if (p == 2)
				write_reg(REG_SPARE, svpwm_pkg::CFG_DATA_W'($urandom()));
			no_gaps = PHASES[p].no_gaps;
			hold_off_req = PHASES[p].hold_off;
			for (int n = 0; n < PHASES[p].words; n++) begin
				if (PHASES[p].pause && n == PHASES[p].words / 2)
					wait_for_results();
				send_word(draw_component(), draw_component(), 1'b0, '0);
			end
		end
		wait_for_results();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### files.f
hdl/svpwm_pkg.sv
hdl/svpwm_if.sv
hdl/svpwm_xform.sv
hdl/svpwm_timing.sv
hdl/space_vector_pwm_timing_core.sv
bench/tb_top.sv
